// ===== hdl/qwt_pkg.sv =====
package qwt_pkg;

	// Byte codes with a lexical role
	localparam logic [7:0] ChNewline   = 8'h0A;
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChHash      = 8'h23;
	localparam logic [7:0] ChSpace     = 8'h20;
	localparam logic [7:0] ChTab       = 8'h09;
	localparam logic [7:0] ChCr        = 8'h0D;

	// Position of the lexer relative to words
	typedef enum logic [1:0] {
		MODE_GAP   = 2'd0,
		MODE_WORD  = 2'd1,
		MODE_QUOTE = 2'd2
	} lex_mode_t;

	typedef struct packed {
		lex_mode_t mode;
		logic      escape_pending;
		logic      skipping_comment;
		logic      line_has_word;
	} lex_state_t;

	typedef struct packed {
		logic       has_char;
		logic [7:0] out_char;
		logic       starts_word;
		logic       ends_word;
		logic       ends_line;
	} lex_result_t;

endpackage

// ===== hdl/qwt_lex.sv =====
module qwt_lex (
	input  qwt_pkg::lex_state_t  cur,
	input  logic [7:0]           in_byte,
	output qwt_pkg::lex_state_t  nxt,
	output logic                 emit,
	output qwt_pkg::lex_result_t res
);
	import qwt_pkg::*;

	logic open_w;
	logic is_blank;

	assign open_w   = (cur.mode == MODE_WORD) || (cur.mode == MODE_QUOTE);
	assign is_blank = (in_byte == ChSpace) || (in_byte == ChTab) || (in_byte == ChCr);

	// One decision per byte; newline, comment skip and escape take priority
	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '0;
		if ((cur.mode != MODE_WORD) && (cur.mode != MODE_QUOTE))
			nxt.mode = MODE_GAP;
		priority if (in_byte == ChNewline) begin
			nxt            = '0;
			nxt.mode       = MODE_GAP;
			emit           = cur.line_has_word | open_w;
			res.ends_word  = open_w;
			res.ends_line  = cur.line_has_word | open_w;
		end else if (cur.skipping_comment) begin
			emit = 1'b0;
		end else if (cur.escape_pending) begin
			// literal byte, may start a word
			nxt.escape_pending = 1'b0;
			nxt.line_has_word  = 1'b1;
			if (!open_w)
				nxt.mode = MODE_WORD;
			emit            = 1'b1;
			res.has_char    = 1'b1;
			res.out_char    = in_byte;
			res.starts_word = !open_w;
		end else if (in_byte == ChBackslash) begin
			nxt.escape_pending = 1'b1;
		end else if (is_blank) begin
			unique case (cur.mode)
				MODE_WORD: begin
					nxt.mode      = MODE_GAP;
					emit          = 1'b1;
					res.ends_word = 1'b1;
				end
				MODE_QUOTE: begin
					emit         = 1'b1;
					res.has_char = 1'b1;
					res.out_char = in_byte;
				end
				default: nxt.mode = MODE_GAP;
			endcase
		end else if (in_byte == ChQuote) begin
			unique case (cur.mode)
				MODE_WORD:  nxt.mode = MODE_QUOTE;
				MODE_QUOTE: nxt.mode = MODE_WORD;
				default: begin
					// quote between words opens a (possibly empty) word
					nxt.mode          = MODE_QUOTE;
					nxt.line_has_word = 1'b1;
					emit              = 1'b1;
					res.starts_word   = 1'b1;
				end
			endcase
		end else if (in_byte == ChHash) begin
			nxt.mode             = MODE_GAP;
			nxt.skipping_comment = 1'b1;
			emit                 = open_w;
			res.ends_word        = open_w;
		end else begin
			// ordinary word character
			nxt.line_has_word = 1'b1;
			if (!open_w)
				nxt.mode = MODE_WORD;
			emit            = 1'b1;
			res.has_char    = 1'b1;
			res.out_char    = in_byte;
			res.starts_word = !open_w;
		end
	end

endmodule

// ===== hdl/quoted_word_tokenizer.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_ready    in_byte
// output    out_valid/out_ready  has_char, out_char, starts_word, ends_word, ends_line
//
// One byte per cycle while the output is not stalled: the lexer state updates as a
// byte is taken, and its result is captured in the output register at the same edge.
// Bytes that give no result leave the output register untouched or empty.
// in_ready is high whenever the output register is empty or being drained,
// so a full register stalls input only while out_ready is low.
// Reset clears the lexer state and the output valid flag.
module quoted_word_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       has_char,
	output logic [7:0] out_char,
	output logic       starts_word,
	output logic       ends_word,
	output logic       ends_line
);
	import qwt_pkg::*;

	lex_state_t  state_q;
	lex_state_t  state_nxt;
	lex_result_t res_c;
	lex_result_t res_q;
	logic        emit_c;
	logic        out_valid_q;
	logic        accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	qwt_lex u_lex (
		.cur     (state_q),
		.in_byte (in_byte),
		.nxt     (state_nxt),
		.emit    (emit_c),
		.res     (res_c)
	);

	// Lexer state advances on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid && emit_c;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept && emit_c) begin
			res_q <= res_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign has_char    = res_q.has_char;
	assign out_char    = res_q.out_char;
	assign starts_word = res_q.starts_word;
	assign ends_word   = res_q.ends_word;
	assign ends_line   = res_q.ends_line;

endmodule
